/* sv/skis_pkg.sv */
// Shared package for the sorted-key interpolation search block.
// Holds default sizes, port widths, function codes and the control word
// that the sequencer hands to the start-index unit. No dependencies.
`default_nettype none

package skis_pkg;

   // Default table geometry.
   localparam int unsigned DEF_TABLE_DEPTH = 4096;
   localparam int unsigned DEF_KEY_BITS    = 48;

   // Fixed widths of the payload ports.
   localparam int unsigned KEY_PORT_BITS   = 48;
   localparam int unsigned INDEX_PORT_BITS = 12;

   // Function codes of an input word.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Control word for the start-index unit.
   typedef struct packed {
      logic mul_en;   // capture a new partial product
      logic sel_hi;   // use the upper key half and keep the lower product
   } skis_mctl_type;

endpackage

`default_nettype wire

/* sv/skis_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the key table. No package dependencies.
`default_nettype none

module skis_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/skis_start.sv */
// Start-index unit: floor(key * TABLE_DEPTH / 2^KEY_BITS), computed with one
// shared 32-bit by depth-width multiplier used on two key halves in turn.
// Depends on skis_pkg for the control word type.
`default_nettype none

module skis_start #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned KEY_BITS    = 48
) (
   input  wire logic                           clock,
   input  wire logic [KEY_BITS-1:0]            key,
   input  wire skis_pkg::skis_mctl_type        ctl,
   output logic      [$clog2(TABLE_DEPTH)-1:0] start
);

   import skis_pkg::*;

   localparam int unsigned IW   = $clog2(TABLE_DEPTH);
   localparam int unsigned DW   = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PW   = 32 + DW;
   localparam int unsigned SUMW = 64 + DW;

   logic [63:0]     key_ext;
   logic [31:0]     op_a;
   logic [PW-1:0]   prod_in;
   logic [PW-1:0]   prod_ff;
   logic [PW-1:0]   acc_ff;
   logic [SUMW-1:0] sum;

   // Pick the key half for this pass and multiply by the table depth.
   assign key_ext = 64'(key);
   assign op_a    = ctl.sel_hi ? key_ext[63:32] : key_ext[31:0];
   assign prod_in = PW'(op_a) * PW'(TABLE_DEPTH);

   // The lower-half product moves to the accumulator when the upper half runs.
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.sel_hi) begin
         acc_ff <= prod_ff;
      end
   end

   // Combine both partial products; the shift by the key width is a select.
   assign sum   = SUMW'(acc_ff) + (SUMW'(prod_ff) << 32);
   assign start = sum[KEY_BITS +: IW];

endmodule

`default_nettype wire

/* sv/sorted_key_interpolation_search.sv */
// Sorted-key interpolation search. The block holds a table of ascending,
// unique keys in a RAM. A load word (func = 0) writes its key at a load
// pointer that counts up and stops at the table depth; it gives no result
// and leaves the block idle. A lookup word (func = 1) gives one result
// word: the search starts at index (key * depth) >> key width, then walks
// down while the stored key is larger or up while it is smaller, stopping
// at the table ends, and reports found and the index (0 when not found).
// Lookups are meaningful only after the whole table has been loaded. A
// lookup keeps the block busy from acceptance until it is ready again:
// two passes of the shared multiplier and one add give the start index,
// each probe has a RAM address state and a compare state behind the
// registered read port, and a delivery state moves the result into the
// output register once that register is free. A finished result waits in
// the output register while the next word is accepted.
// Depends on skis_pkg, skis_ram and skis_start.
`default_nettype none

module sorted_key_interpolation_search #(
   parameter int unsigned TABLE_DEPTH = skis_pkg::DEF_TABLE_DEPTH,
   parameter int unsigned KEY_BITS    = skis_pkg::DEF_KEY_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_func,
   input  wire logic [skis_pkg::KEY_PORT_BITS-1:0]    req_key,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_found,
   output logic      [skis_pkg::INDEX_PORT_BITS-1:0]  rsp_index
);

   import skis_pkg::*;

   localparam int unsigned IW   = $clog2(TABLE_DEPTH);
   localparam int unsigned PTRW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MLO,
      ST_MHI,
      ST_ADD,
      ST_RD,
      ST_CMP,
      ST_PUT
   } state_type;

   state_type           state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                dir_ff, dir_in;
   logic                first_ff, first_in;
   logic                hit_ff, hit_in;
   logic [PTRW-1:0]     ptr_ff, ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [INDEX_PORT_BITS-1:0] rsp_index_ff, rsp_index_in;

   logic [63:0]         req_key_ext;
   logic [KEY_BITS-1:0] req_key_m;
   logic                accept;
   logic                wr_en;
   logic [KEY_BITS-1:0] rd_data;
   logic [IW-1:0]       start;
   skis_mctl_type       mctl;
   logic                gt, lt, down, go_on;
   logic [31:0]         idx_wide;

   // Mask the incoming key to the configured key width.
   assign req_key_ext = 64'(req_key);
   assign req_key_m   = req_key_ext[KEY_BITS-1:0];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_func == FUNC_LOAD) && (ptr_ff < PTRW'(TABLE_DEPTH));

   // Key table.
   skis_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff[IW-1:0]),
      .wr_data (req_key_m),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Start-index unit, driven by the sequencer.
   assign mctl.mul_en = (state_ff == ST_MLO) || (state_ff == ST_MHI);
   assign mctl.sel_hi = (state_ff == ST_MHI);

   skis_start #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_start (
      .clock (clock),
      .key   (key_ff),
      .ctl   (mctl),
      .start (start)
   );

   // Probe decision: the first compare sets the walk direction.
   assign gt    = rd_data > key_ff;
   assign lt    = rd_data < key_ff;
   assign down  = first_ff ? gt : dir_ff;
   assign go_on = down ? (gt && (idx_ff != '0))
                       : (lt && (idx_ff != IW'(TABLE_DEPTH - 1)));
   assign idx_wide = 32'(idx_ff);

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      dir_in       = dir_ff;
      first_in     = first_ff;
      hit_in       = hit_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_key_m;
               if (req_func == FUNC_LOOKUP) begin
                  state_in = ST_MLO;
               end else if (wr_en) begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_MLO: begin
            state_in = ST_MHI;
         end
         ST_MHI: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            idx_in   = start;
            first_in = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (go_on) begin
               idx_in   = down ? (idx_ff - 1'b1) : (idx_ff + 1'b1);
               dir_in   = down;
               first_in = 1'b0;
               state_in = ST_RD;
            end else begin
               hit_in   = !gt && !lt;
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? idx_wide[INDEX_PORT_BITS-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs; reset clears control only.
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      dir_ff       <= dir_in;
      first_ff     <= first_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_index = rsp_index_ff;

   // A new result word appears only after the delivery state.
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("result word appeared outside the delivery state");

   // The table is written only while the block is idle.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("table write while a lookup is running");

   // The load pointer never passes the table depth.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTRW'(TABLE_DEPTH))
      else $error("load pointer beyond table depth");

   // The load pointer moves only on an accepted load word.
   a_ptr_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && (req_func == FUNC_LOAD)) |=> $stable(ptr_ff))
      else $error("load pointer moved without a load word");

   // A miss always reports index zero.
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_index_ff == '0))
      else $error("miss reported with a nonzero index");

endmodule

`default_nettype wire

/* tb/sorted_key_interpolation_search_test.sv */
// Testbench for the sorted-key interpolation search block: loads a full key
// table, then checks lookups against a table walk kept in the testbench.
// Depends on skis_pkg and sorted_key_interpolation_search.
`timescale 1ns / 1ps

module sorted_key_interpolation_search_test;

   import skis_pkg::*;

   localparam int unsigned TBL_DEPTH   = DEF_TABLE_DEPTH;
   localparam int unsigned ADDR_W      = $clog2(TBL_DEPTH);
   localparam int unsigned KEY_W       = KEY_PORT_BITS;
   localparam int unsigned IDX_W       = INDEX_PORT_BITS;
   localparam int unsigned CYCLE_LIMIT = 3000000;
   localparam int unsigned SETTLE_CYCLES = 300;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
   } search_word_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } search_answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_func = FUNC_LOAD;
   logic [KEY_W-1:0] req_key = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_found;
   logic [IDX_W-1:0] rsp_index;

   // Testbench copy of the block state.
   logic [KEY_W-1:0] key_store [TBL_DEPTH];
   int unsigned      keys_loaded = 0;

   search_word_type   pending_words [$];
   search_answer_type pending_answers [$];
   logic [KEY_W-1:0]  table_keys [TBL_DEPTH];

   bit               idling_on = 1'b1;
   int unsigned      send_gap = 0;
   int unsigned      recv_gap = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   sorted_key_interpolation_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_key   (req_key),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_found (rsp_found),
      .rsp_index (rsp_index)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Interpolated start, then walk toward the key until the comparison turns
   // or the table ends; report the stopping entry if it matches.
   function automatic search_answer_type search_table(input logic [KEY_W-1:0] probe_key);
      logic [63:0]       product;
      int unsigned       pos;
      logic [KEY_W-1:0]  stored;
      search_answer_type answer;
      product = 64'(probe_key) * 64'(TBL_DEPTH);
      pos = int'(product >> DEF_KEY_BITS);
      if (pos >= TBL_DEPTH) begin
         pos = TBL_DEPTH - 1;
      end
      stored = key_store[ADDR_W'(pos)];
      if (stored > probe_key) begin
         while (stored > probe_key && pos > 0) begin
            pos--;
            stored = key_store[ADDR_W'(pos)];
         end
      end else if (stored < probe_key) begin
         while (stored < probe_key && pos < TBL_DEPTH - 1) begin
            pos++;
            stored = key_store[ADDR_W'(pos)];
         end
      end
      answer.found = (stored == probe_key);
      answer.index = answer.found ? IDX_W'(pos) : '0;
      return answer;
   endfunction

   // Apply one accepted word to the model state.
   function automatic void absorb_word(input logic func, input logic [KEY_W-1:0] key);
      if (func == FUNC_LOAD) begin
         if (keys_loaded < TBL_DEPTH) begin
            key_store[ADDR_W'(keys_loaded)] = key;
            keys_loaded++;
         end
      end else begin
         pending_answers = {pending_answers, search_table(key)};
      end
   endfunction

   function automatic void queue_word(input logic func, input logic [KEY_W-1:0] key);
      search_word_type word;
      word.func = func;
      word.key  = key;
      pending_words = {pending_words, word};
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Request driver: takes words from the pending queue, with random idle bursts.
   always @(posedge clock) begin : request_driver
      search_word_type word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_word(req_func, req_key);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(0, 11);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_func  <= word.func;
               req_key   <= word.key;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      search_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("Unexpected result word: found=%0d index=%0d",
                           rsp_found, rsp_index);
               end
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_found !== want.found || rsp_index !== want.index) begin
                  if (mismatch_count < 10) begin
                     $display("Mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                              want.found, want.index, rsp_found, rsp_index);
                  end
                  mismatch_count++;
               end
            end
         end
         // Random stall bursts on the result side.
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Wait until every queued word is sent and every answer has come back.
   task automatic wait_for_drain();
      while (pending_words.size() > 0 || req_valid || pending_answers.size() > 0) begin
         @(negedge clock);
      end
   endtask

   // Random lookups, mostly of stored keys, with some ignored loads mixed in.
   task automatic queue_random_words(input int unsigned count);
      int unsigned pick;
      logic [KEY_W-1:0] base;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) begin
            queue_word(FUNC_LOAD, random_key());
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            queue_word(FUNC_LOOKUP,
                       table_keys[ADDR_W'($urandom_range(0, TBL_DEPTH - 1))]);
         end else if (pick < 75) begin
            base = ($urandom_range(0, 1) == 0) ? (KEY_W'(1000) << 36) : (KEY_W'(2048) << 36);
            queue_word(FUNC_LOOKUP, base + KEY_W'({$urandom, $urandom} & 64'h3FF_FFFF_FFFF));
         end else begin
            queue_word(FUNC_LOOKUP, random_key());
         end
      end
   endtask

   // Stimulus: full table load, directed lookups, then random lookups.
   initial begin
      // One key per 2^36 interval so most lookups start on their key. Two
      // packed clusters force long walks down and up; one swapped pair and
      // one duplicate leave the table slightly out of order.
      for (int unsigned i = 0; i < TBL_DEPTH; i++) begin
         if (i >= 1000 && i <= 1063) begin
            table_keys[ADDR_W'(i)] = (KEY_W'(1063) << 36) + (KEY_W'(i - 1000) << 30)
                                   + KEY_W'(30'($urandom));
         end else if (i >= 2048 && i <= 2111) begin
            table_keys[ADDR_W'(i)] = (KEY_W'(2048) << 36) + (KEY_W'(i - 2048) << 30)
                                   + KEY_W'(30'($urandom));
         end else begin
            table_keys[ADDR_W'(i)] = (KEY_W'(i) << 36) + KEY_W'(36'({$urandom, $urandom}));
         end
      end
      table_keys[0]    = KEY_W'(5);
      table_keys[4095] = 48'hFFFF_FFFF_FFFE;
      table_keys[3000] = table_keys[3001];
      table_keys[3001] = (KEY_W'(3000) << 36) + KEY_W'(36'({$urandom, $urandom}));
      table_keys[3501] = table_keys[3500];

      for (int unsigned i = 0; i < TBL_DEPTH; i++) begin
         queue_word(FUNC_LOAD, table_keys[ADDR_W'(i)]);
      end

      // Directed lookups at the table ends, cluster edges and disorder.
      queue_word(FUNC_LOOKUP, '0);
      queue_word(FUNC_LOOKUP, table_keys[0]);
      queue_word(FUNC_LOOKUP, table_keys[1]);
      queue_word(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFF);
      queue_word(FUNC_LOOKUP, table_keys[4095]);
      queue_word(FUNC_LOOKUP, table_keys[4094]);
      queue_word(FUNC_LOOKUP, table_keys[4094] + KEY_W'(1));
      queue_word(FUNC_LOOKUP, KEY_W'(1000) << 36);
      queue_word(FUNC_LOOKUP, table_keys[1000]);
      queue_word(FUNC_LOOKUP, table_keys[1063]);
      queue_word(FUNC_LOOKUP, table_keys[2048]);
      queue_word(FUNC_LOOKUP, table_keys[2111]);
      queue_word(FUNC_LOOKUP, KEY_W'(2111) << 36);
      queue_word(FUNC_LOOKUP, table_keys[2112]);
      queue_word(FUNC_LOOKUP, table_keys[3000]);
      queue_word(FUNC_LOOKUP, table_keys[3001]);
      queue_word(FUNC_LOOKUP, table_keys[3500]);
      // Loads into a full table must be dropped.
      queue_word(FUNC_LOAD, 48'hFFFF_FFFF_FFFF);
      queue_word(FUNC_LOAD, '0);
      queue_word(FUNC_LOOKUP, 48'hFFFF_FFFF_FFFF);
      queue_word(FUNC_LOOKUP, table_keys[2047]);
      queue_word(FUNC_LOOKUP, table_keys[2047] + KEY_W'(1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_random_words(500);
      wait_for_drain();
      queue_random_words(500);
      wait_for_drain();

      // Final stretch runs with both sides at full rate.
      idling_on = 1'b0;
      queue_random_words(150);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (pending_answers.size() != 0) begin
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
